FILE: hw/rtl/ssc_pkg.sv
// ============================================================================
// ssc_pkg
// Shared types, constants and rounding helpers for the smooth switch datapath.
// ============================================================================
package ssc_pkg;

  localparam int TaylorTerms = 12;
  localparam int FrontStages = 7;
  localparam int ExpStages   = 3 * TaylorTerms + 1;
  localparam int MultStages  = 5;

  localparam logic signed [25:0] ONE_Q24   = 26'sd16777216;
  localparam logic [30:0]        LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;
  localparam logic [30:0]        TERM_ONE  = 31'd1073741824;
  localparam logic [47:0]        G_MAX     = 48'hFFFF_FFFF_FFFF;

  // floor(2^32 / k) for k = 1 .. TaylorTerms
  localparam logic [32:0] RECIP [TaylorTerms] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
  };

  typedef enum logic [2:0] {
    CFG_OFF_LEVEL = 3'd0,
    CFG_INV_SPAN  = 3'd1,
    CFG_G_ON      = 3'd2,
    CFG_G_OFF     = 3'd3,
    CFG_LOG_MID   = 3'd4,
    CFG_LOG_RATIO = 3'd5,
    CFG_START_ON  = 3'd6
  } cfg_idx_e;

  localparam logic [1:0] REGION_OFF   = 2'd0;
  localparam logic [1:0] REGION_ON    = 2'd1;
  localparam logic [1:0] REGION_TRANS = 2'd2;

  typedef struct packed {
    logic signed [31:0] off_level;
    logic signed [31:0] inv_span;
    logic [47:0]        g_on;
    logic [47:0]        g_off;
    logic signed [31:0] log_mid;
    logic signed [31:0] log_ratio;
    logic               start_on;
  } cfg_t;

  typedef struct packed {
    logic               init;
    logic [1:0]         region;
    logic signed [32:0] vd;
    logic signed [64:0] u;
    logic signed [25:0] s24;
    logic [24:0]        am;
    logic [25:0]        s2;
    logic signed [27:0] poly;
    logic signed [27:0] cpre;
    logic signed [35:0] e;
    logic signed [35:0] c;
    logic signed [39:0] y;
    logic signed [67:0] d;
    logic signed [15:0] n;
    logic [29:0]        z;
    logic [63:0]        dmag;
    logic [30:0]        term;
    logic [32:0]        acc;
    logic [30:0]        p;
    logic [30:0]        q0;
    logic [47:0]        g;
    logic [32:0]        vmag;
    logic [56:0]        pb0;
    logic [56:0]        pb1;
    logic [5:0][45:0]   ps;
    logic [80:0]        bp;
    logic [89:0]        spl;
    logic [89:0]        sph;
    logic [112:0]       sp;
    logic [47:0]        branch;
    logic [47:0]        slope;
  } pipe_t;

  // round to nearest, ties away from zero, then arithmetic shift by k
  function automatic logic signed [127:0] rnd_s(input logic signed [127:0] x,
                                                input int unsigned k);
    logic signed [127:0] h;
    h = $signed(128'd1 << (k - 1)) - $signed({127'd0, x[127]});
    return (x + h) >>> k;
  endfunction

  // round magnitude by k, clamp to 48-bit signed range, apply sign
  function automatic logic [47:0] sat_round(input logic [112:0] p, input int unsigned k,
                                            input logic neg);
    logic [112:0] r;
    logic [112:0] lim;
    r   = (p + (113'd1 << (k - 1))) >> k;
    lim = neg ? (113'd1 << 47) : ((113'd1 << 47) - 113'd1);
    if (r > lim) r = lim;
    return neg ? (48'd0 - r[47:0]) : r[47:0];
  endfunction

endpackage

FILE: hw/rtl/ssc_if.sv
// ============================================================================
// ssc interfaces
// Valid/ready channels for input beats, result beats and register writes.
// ============================================================================
interface ssc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] control;
  logic signed [31:0] pos_voltage;
  logic signed [31:0] neg_voltage;
  logic               init_phase;
  modport source(output valid, control, pos_voltage, neg_voltage, init_phase, input ready);
  modport sink(input valid, control, pos_voltage, neg_voltage, init_phase, output ready);
endinterface

interface ssc_out_if;
  logic               valid;
  logic               ready;
  logic [47:0]        conductance;
  logic signed [47:0] branch_current;
  logic signed [47:0] control_slope;
  logic [1:0]         region;
  modport source(output valid, conductance, branch_current, control_slope, region,
                 input ready);
  modport sink(input valid, conductance, branch_current, control_slope, region,
               output ready);
endinterface

interface ssc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ssc_front.sv
// ============================================================================
// ssc_front
// Normalize control, classify region, build the exponent and slope factor.
// ============================================================================
module ssc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] control_i,
  input  logic signed [31:0] pos_voltage_i,
  input  logic signed [31:0] neg_voltage_i,
  input  logic               init_phase_i,
  input  ssc_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output ssc_pkg::pipe_t     data_o
);
  import ssc_pkg::*;

  pipe_t            st_d [FrontStages];
  pipe_t            st_q [FrontStages];
  logic [FrontStages-1:0] vl_q;

  always_comb begin
    logic signed [32:0]  ctl_m;
    logic [49:0]         sq;
    logic signed [26:0]  fac;
    logic signed [52:0]  pp;
    logic signed [27:0]  sd;
    logic signed [59:0]  tp;
    logic signed [59:0]  cp;
    logic signed [127:0] rr;
    logic signed [67:0]  ym;
    logic [53:0]         zp;
    pipe_t               t;

    t          = '0;
    ctl_m      = 33'(control_i) - 33'(cfg_i.off_level);
    t.u        = ctl_m * 65'(cfg_i.inv_span);
    t.vd       = 33'(pos_voltage_i) - 33'(neg_voltage_i);
    t.init     = init_phase_i;
    st_d[0]    = t;

    t = st_q[0];
    if (t.init) begin
      t.region = cfg_i.start_on ? REGION_ON : REGION_OFF;
    end else if (t.u >= 65'sd4294967296) begin
      t.region = REGION_ON;
    end else if (t.u <= 65'sd0) begin
      t.region = REGION_OFF;
    end else begin
      t.region = REGION_TRANS;
    end
    t.s24   = $signed({1'b0, t.u[31:8], 1'b0}) - ONE_Q24;
    t.am    = t.s24[25] ? 25'(-t.s24) : 25'(t.s24);
    st_d[1] = t;

    t       = st_q[1];
    sq      = t.am * t.am;
    t.s2    = 26'((sq + 50'd8388608) >> 24);
    st_d[2] = t;

    t       = st_q[2];
    fac     = 27'sd50331648 - $signed({1'b0, t.s2});
    pp      = t.s24 * fac;
    rr      = rnd_s(128'(pp), 24);
    t.poly  = rr[27:0];
    sd      = $signed({2'b00, t.s2}) - 28'sd16777216;
    t.cpre  = sd * 28'sd3;
    st_d[3] = t;

    t       = st_q[3];
    tp      = cfg_i.log_ratio * t.poly;
    rr      = rnd_s(128'(tp), 26);
    t.e     = -36'(cfg_i.log_mid) - $signed(rr[35:0]);
    cp      = cfg_i.log_ratio * t.cpre;
    rr      = rnd_s(128'(cp), 25);
    t.c     = rr[35:0];
    st_d[4] = t;

    t       = st_q[4];
    ym      = t.e * $signed({1'b0, LOG2E_Q30});
    rr      = rnd_s(128'(ym), 30);
    t.y     = rr[39:0];
    t.d     = t.c * 68'(cfg_i.inv_span);
    st_d[5] = t;

    t       = st_q[5];
    t.n     = 16'(t.y >>> 24);
    zp      = t.y[23:0] * LN2_Q30;
    t.z     = 30'((zp + 54'd8388608) >> 24);
    t.dmag  = t.d[67] ? 64'(-t.d) : 64'(t.d);
    st_d[6] = t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[FrontStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = vl_q[FrontStages-1];
  assign data_o  = st_q[FrontStages-1];

endmodule

FILE: hw/rtl/ssc_exp.sv
// ============================================================================
// ssc_exp
// Taylor series of 2^f, three stages per term, then scale into Q8.40.
// ============================================================================
module ssc_exp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  ssc_pkg::pipe_t data_i,
  output logic           valid_o,
  output ssc_pkg::pipe_t data_o
);
  import ssc_pkg::*;

  pipe_t                st_d [ExpStages];
  pipe_t                st_q [ExpStages];
  logic [ExpStages-1:0] vl_q;
  pipe_t                first;

  always_comb begin
    first      = data_i;
    first.term = TERM_ONE;
    first.acc  = 33'(TERM_ONE);
  end

  for (genvar gk = 0; gk < TaylorTerms; gk++) begin : g_term
    pipe_t prev;
    if (gk == 0) begin : g_head
      assign prev = first;
    end else begin : g_link
      assign prev = st_q[3*gk-1];
    end

    always_comb begin
      logic [60:0] tz;
      pipe_t       t;
      t              = prev;
      tz             = t.term * t.z;
      t.p            = 31'((tz + 61'd536870912) >> 30);
      st_d[3*gk]     = t;
    end

    always_comb begin
      logic [63:0] pr;
      pipe_t       t;
      t              = st_q[3*gk];
      pr             = t.p * RECIP[gk];
      t.q0           = 31'(pr >> 32);
      st_d[3*gk+1]   = t;
    end

    always_comb begin
      logic [34:0] rem;
      logic [30:0] q;
      pipe_t       t;
      t              = st_q[3*gk+1];
      rem            = 35'(t.p) - t.q0 * 35'(gk + 1);
      q              = (rem >= 35'(gk + 1)) ? t.q0 + 31'd1 : t.q0;
      t.term         = q;
      t.acc          = t.acc + 33'(q);
      st_d[3*gk+2]   = t;
    end
  end

  always_comb begin
    logic signed [15:0] sh;
    logic [15:0]        m;
    logic [5:0]         m6;
    pipe_t              t;
    t  = st_q[ExpStages-2];
    sh = t.n + 16'sd10;
    m  = 16'(-sh);
    m6 = m[5:0];
    if (!sh[15]) begin
      if (sh > 16'sd17) begin
        t.g = G_MAX;
      end else if (48'(t.acc) > (G_MAX >> sh[4:0])) begin
        t.g = G_MAX;
      end else begin
        t.g = 48'(t.acc) << sh[4:0];
      end
    end else if (m >= 16'd40) begin
      t.g = '0;
    end else begin
      t.g = 48'((64'(t.acc) + (64'd1 << (m6 - 6'd1))) >> m6);
    end
    st_d[ExpStages-1] = t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[ExpStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = vl_q[ExpStages-1];
  assign data_o  = st_q[ExpStages-1];

endmodule

FILE: hw/rtl/ssc_mult.sv
// ============================================================================
// ssc_mult
// Select conductance, form current and slope from partial products, saturate.
// ============================================================================
module ssc_mult (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  ssc_pkg::pipe_t data_i,
  input  ssc_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output ssc_pkg::pipe_t data_o
);
  import ssc_pkg::*;

  pipe_t                 st_d [MultStages];
  pipe_t                 st_q [MultStages];
  logic [MultStages-1:0] vl_q;

  always_comb begin
    logic [65:0] dm;
    pipe_t       t;

    t = data_i;
    if (t.region == REGION_ON) begin
      t.g = cfg_i.g_on;
    end else if (t.region == REGION_OFF) begin
      t.g = cfg_i.g_off;
    end
    t.vmag  = t.vd[32] ? 33'(-t.vd) : 33'(t.vd);
    st_d[0] = t;

    t     = st_q[0];
    dm    = {2'b00, t.dmag};
    t.pb0 = t.vmag * t.g[23:0];
    t.pb1 = t.vmag * t.g[47:24];
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        t.ps[i*3+j] = t.g[24*i +: 24] * dm[22*j +: 22];
      end
    end
    st_d[1] = t;

    t       = st_q[1];
    t.bp    = (81'(t.pb1) << 24) + 81'(t.pb0);
    t.spl   = 90'(t.ps[0]) + (90'(t.ps[1]) << 22) + (90'(t.ps[2]) << 44);
    t.sph   = 90'(t.ps[3]) + (90'(t.ps[4]) << 22) + (90'(t.ps[5]) << 44);
    st_d[2] = t;

    t        = st_q[2];
    t.sp     = (113'(t.sph) << 24) + 113'(t.spl);
    t.branch = sat_round(113'(t.bp), 24, t.vd[32]);
    st_d[3]  = t;

    t       = st_q[3];
    t.slope = (t.region == REGION_TRANS) ? sat_round(t.sp, 40, t.d[67]) : '0;
    st_d[4] = t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[MultStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = vl_q[MultStages-1];
  assign data_o  = st_q[MultStages-1];

endmodule

FILE: hw/rtl/smooth_switch_conductance_top.sv
// ============================================================================
// smooth_switch_conductance_top
// Per-sample evaluation of a smoothly controlled switch conductance.
// ============================================================================
// One beat enters per clock while the pipeline advances, and the whole
// datapath is a single 49-stage pipeline (7 front stages, 37 for the exponent
// series and scaling, 5 for the output products), and it advances whenever the
// result register is empty or being taken, so the sustained rate is one beat
// per cycle while results are taken. Register writes are always accepted and
// must only happen while the pipeline is empty.
module smooth_switch_conductance_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssc_in_if.sink    in_i,
  ssc_out_if.source out_o,
  ssc_cfg_if.sink   cfg_i
);
  import ssc_pkg::*;

  cfg_t  cfg_q;
  logic  en;
  logic  f_valid;
  pipe_t f_data;
  logic  e_valid;
  pipe_t e_data;
  logic  m_valid;
  pipe_t m_data;

  assign en          = !m_valid || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_level <= 32'sd0;
      cfg_q.inv_span  <= 32'sd65536;
      cfg_q.g_on      <= 48'd1099511627776;
      cfg_q.g_off     <= 48'd1099512;
      cfg_q.log_mid   <= 32'sd115892897;
      cfg_q.log_ratio <= -32'sd231785794;
      cfg_q.start_on  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_OFF_LEVEL: cfg_q.off_level <= cfg_i.data[31:0];
        CFG_INV_SPAN:  cfg_q.inv_span  <= cfg_i.data[31:0];
        CFG_G_ON:      cfg_q.g_on      <= cfg_i.data;
        CFG_G_OFF:     cfg_q.g_off     <= cfg_i.data;
        CFG_LOG_MID:   cfg_q.log_mid   <= cfg_i.data[31:0];
        CFG_LOG_RATIO: cfg_q.log_ratio <= cfg_i.data[31:0];
        CFG_START_ON:  cfg_q.start_on  <= cfg_i.data[0];
        default:       ;
      endcase
    end
  end

  ssc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_i.valid),
    .control_i     (in_i.control),
    .pos_voltage_i (in_i.pos_voltage),
    .neg_voltage_i (in_i.neg_voltage),
    .init_phase_i  (in_i.init_phase),
    .cfg_i         (cfg_q),
    .valid_o       (f_valid),
    .data_o        (f_data)
  );

  ssc_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .data_i  (f_data),
    .valid_o (e_valid),
    .data_o  (e_data)
  );

  ssc_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid),
    .data_i  (e_data),
    .cfg_i   (cfg_q),
    .valid_o (m_valid),
    .data_o  (m_data)
  );

  assign out_o.valid          = m_valid;
  assign out_o.conductance    = m_data.g;
  assign out_o.branch_current = m_data.branch;
  assign out_o.control_slope  = m_data.slope;
  assign out_o.region         = m_data.region;

endmodule

FILE: hw/rtl/ssc_checker.sv
// ============================================================================
// ssc_checker
// Port-level checks on result beats and backpressure of the switch block.
// ============================================================================
module ssc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [47:0] conductance_i,
  input logic [47:0] branch_i,
  input logic [47:0] slope_i,
  input logic [1:0]  region_i
);
  import ssc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(conductance_i) &&
      $stable(branch_i) && $stable(slope_i) && $stable(region_i))
    else $error("stalled result beat changed");

  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  a_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> region_i != 2'd3)
    else $error("bad region code");

  a_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && region_i != REGION_TRANS |-> slope_i == 48'd0)
    else $error("slope nonzero outside transition");

endmodule

bind smooth_switch_conductance_top ssc_checker u_ssc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .conductance_i (out_o.conductance),
  .branch_i      (out_o.branch_current),
  .slope_i       (out_o.control_slope),
  .region_i      (out_o.region)
);

FILE: test/smooth_switch_conductance_checker.sv
// ----------------------------------------------------------------------------
// Smooth switch conductance checker
// Watches the input, result and register channels. Keeps its own copy of the
// registers, predicts every result of an accepted input beat and compares the
// result beats against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module smooth_switch_conductance_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ssc_in_if    in_ch,
  ssc_out_if   out_ch,
  ssc_cfg_if   cfg_ch,
  output int   mismatches_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssc_pkg::*;

  typedef struct packed {
    logic [47:0] conductance;
    logic [47:0] current;
    logic [47:0] slope;
    logic [1:0]  region;
  } switch_eval_t;

  cfg_t         regs;
  switch_eval_t due_q[$];
  int           mismatches;

  localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

  function automatic logic signed [127:0] round_shift(input logic signed [127:0] x,
                                                      input int k);
    logic [127:0] m;
    m = x < 0 ? -x : x;
    m = (m + (128'd1 << (k - 1))) >> k;
    return x < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [47:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                 input int k, input bit neg);
    logic [128:0] p;
    logic [128:0] lim;
    p   = ({65'd0, a} * {65'd0, b} + (129'd1 << (k - 1))) >> k;
    lim = neg ? (129'd1 << 47) : ((129'd1 << 47) - 129'd1);
    if (p > lim) p = lim;
    return neg ? (48'd0 - p[47:0]) : p[47:0];
  endfunction

  function automatic logic [47:0] exp_conductance(input longint e);
    logic signed [127:0] t;
    longint      y;
    longint      n;
    longint      sh;
    logic [63:0] f;
    logic [63:0] z;
    logic [63:0] acc;
    logic [63:0] term;
    t = e;
    t = t * 128'sd1549082005;
    y = longint'(round_shift(t, 30));
    n = y >>> 24;
    f = y - n * 64'sd16777216;
    z = (f * 64'd744261118 + (64'd1 << 23)) >> 24;
    acc  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * z + (64'd1 << 29)) >> 30) / k;
      acc += term;
    end
    sh = n + 10;
    if (sh >= 0) begin
      if (sh > 17 || acc > ({16'd0, SAT48} >> sh)) return SAT48;
      return 48'(acc << sh);
    end
    if (-sh >= 40) return '0;
    return 48'((acc + (64'd1 << (-sh - 1))) >> (-sh));
  endfunction

  function automatic switch_eval_t eval_switch(input logic signed [31:0] ctl,
                                               input logic signed [31:0] pv,
                                               input logic signed [31:0] nv,
                                               input logic init);
    switch_eval_t        r;
    longint              vd;
    longint              u;
    longint              s24;
    longint              am;
    longint              s2;
    longint              lr;
    logic signed [127:0] w;
    logic signed [127:0] poly;
    logic signed [127:0] term;
    logic signed [127:0] c;
    logic signed [127:0] d;
    logic [47:0]         g;
    r.slope = '0;
    g       = '0;
    if (init) begin
      r.region = regs.start_on ? REGION_ON : REGION_OFF;
    end else begin
      u = (longint'(ctl) - longint'(regs.off_level)) * longint'(regs.inv_span);
      if (u >= 64'sd4294967296) r.region = REGION_ON;
      else if (u <= 0) r.region = REGION_OFF;
      else r.region = REGION_TRANS;
      if (r.region == REGION_TRANS) begin
        lr   = longint'(regs.log_ratio);
        s24  = 2 * (u >>> 8) - 64'sd16777216;
        am   = s24 < 0 ? -s24 : s24;
        s2   = (am * am + (64'sd1 << 23)) >>> 24;
        w    = s24;
        poly = round_shift(w * (128'sd50331648 - s2), 24);
        term = round_shift(lr * poly, 26);
        g    = exp_conductance(-longint'(regs.log_mid) - longint'(term));
        w    = lr;
        c    = round_shift(w * (3 * (s2 - 64'sd16777216)), 25);
        d    = c * longint'(regs.inv_span);
        r.slope = scaled_product(g, 64'(d < 0 ? -d : d), 40, d < 0);
      end
    end
    if (r.region == REGION_ON) g = regs.g_on;
    else if (r.region == REGION_OFF) g = regs.g_off;
    vd = longint'(pv) - longint'(nv);
    r.conductance = g;
    r.current = scaled_product(64'(vd < 0 ? -vd : vd), g, 24, vd < 0);
    return r;
  endfunction

  assign mismatches_o  = mismatches;
  assign outstanding_o = due_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    switch_eval_t want;
    switch_eval_t got;
    if (!rst_ni) begin
      regs <= '{off_level: 32'sd0, inv_span: 32'sd65536, g_on: 48'd1099511627776,
                g_off: 48'd1099512, log_mid: 32'sd115892897, log_ratio: -32'sd231785794,
                start_on: 1'b0};
      mismatches <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_OFF_LEVEL: regs.off_level <= cfg_ch.data[31:0];
          CFG_INV_SPAN:  regs.inv_span  <= cfg_ch.data[31:0];
          CFG_G_ON:      regs.g_on      <= cfg_ch.data;
          CFG_G_OFF:     regs.g_off     <= cfg_ch.data;
          CFG_LOG_MID:   regs.log_mid   <= cfg_ch.data[31:0];
          CFG_LOG_RATIO: regs.log_ratio <= cfg_ch.data[31:0];
          CFG_START_ON:  regs.start_on  <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        due_q.push_back(eval_switch(in_ch.control, in_ch.pos_voltage, in_ch.neg_voltage,
                                    in_ch.init_phase));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.conductance, out_ch.branch_current, out_ch.control_slope,
                out_ch.region};
        if (due_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("result differs: expected g=%h i=%h s=%h r=%0d, got g=%h i=%h s=%h r=%0d",
                       want.conductance, want.current, want.slope, want.region,
                       got.conductance, got.current, got.slope, got.region);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

FILE: test/smooth_switch_conductance_top_test.sv
// ----------------------------------------------------------------------------
// Smooth switch conductance top test
// Drives directed and random input beats through several register settings,
// with random idling on both sides and one long result hold-off, and reports
// the verdict of the checker.
// ----------------------------------------------------------------------------
module smooth_switch_conductance_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssc_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   outstanding;
  int   send_idle;
  int   recv_stall;
  bit   hold_req;
  bit   hold_done;
  logic signed [31:0] cur_off;
  logic signed [31:0] cur_inv;

  ssc_in_if  in_ch();
  ssc_out_if out_ch();
  ssc_cfg_if cfg_ch();

  smooth_switch_conductance_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  smooth_switch_conductance_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("smooth_switch_conductance_top: mismatch");
    $finish;
  end

  initial begin
    int hold_cnt;
    out_ch.ready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done && hold_cnt < 400) begin
        out_ch.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt == 400) hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_beat(input logic signed [31:0] ctl, input logic signed [31:0] pv,
                           input logic signed [31:0] nv, input logic init);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.control     <= ctl;
    in_ch.pos_voltage <= pv;
    in_ch.neg_voltage <= nv;
    in_ch.init_phase  <= init;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic load_settings(input logic signed [31:0] off, input logic signed [31:0] inv,
                               input logic [47:0] gon, input logic [47:0] goff,
                               input logic signed [31:0] lm, input logic signed [31:0] lr,
                               input logic st);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (60) @(posedge clk_i);
    write_reg(CFG_OFF_LEVEL, {16'($urandom), off});
    write_reg(CFG_INV_SPAN, {16'($urandom), inv});
    write_reg(CFG_G_ON, gon);
    write_reg(CFG_G_OFF, goff);
    write_reg(CFG_LOG_MID, {16'($urandom), lm});
    write_reg(CFG_LOG_RATIO, {16'($urandom), lr});
    write_reg(CFG_START_ON, {47'($urandom), st});
    write_reg(CFG_UNUSED, {16'($urandom), 32'($urandom)});
    cfg_ch.valid <= 1'b0;
    cur_off = off;
    cur_inv = inv;
  endtask

  function automatic logic signed [31:0] pick_control();
    longint span;
    longint v;
    if ($urandom_range(2) == 0 || cur_inv == 0) return $urandom;
    span = 64'sd4294967296 / (cur_inv < 0 ? -longint'(cur_inv) : longint'(cur_inv));
    v = longint'($urandom_range(0, 999)) * (span + span / 4 + 1) / 1000 - span / 8;
    if ($urandom_range(9) == 0) v = $urandom_range(0, 1) ? 0 : span;
    v = cur_inv < 0 ? longint'(cur_off) - v : longint'(cur_off) + v;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  task automatic send_random(input int count);
    logic signed [31:0] pv;
    logic signed [31:0] nv;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        pv = $urandom;
        nv = $urandom;
      end else begin
        pv = $signed($urandom_range(0, 2 * 65536 * 20)) - 65536 * 20;
        nv = $signed($urandom_range(0, 65536 * 4)) - 65536 * 2;
      end
      send_beat(pick_control(), pv, nv, $urandom_range(9) == 0);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.control = '0;
    in_ch.pos_voltage = '0;
    in_ch.neg_voltage = '0;
    in_ch.init_phase = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_OFF_LEVEL;
    cfg_ch.data = '0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    send_idle = 19;
    recv_stall = 53;
    cur_off = 0;
    cur_inv = 32'sd65536;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(0, 32'sd65536, 0, 1'b0);
    send_beat(32'sd65536, 32'sd65536, 0, 1'b0);
    send_beat(32'sd32768, 32'sd65536, 0, 1'b0);
    send_beat(1, 32'sd131072, -32'sd65536, 1'b0);
    send_beat(32'sd65535, -32'sd65536, 32'sd65536, 1'b0);
    send_beat(32'sd16384, 32'sd2147483647, -32'sh8000_0000, 1'b0);
    send_beat(32'sd49152, -32'sh8000_0000, 32'sd2147483647, 1'b0);
    send_beat(32'sd2147483647, 32'sd2147483647, -32'sh8000_0000, 1'b0);
    send_beat(-32'sh8000_0000, -32'sh8000_0000, 32'sd2147483647, 1'b0);
    send_beat(-1, 32'sd65536, 0, 1'b0);
    send_beat(32'sd32768, 32'sd65536, 0, 1'b1);
    send_beat(32'sd2147483647, -32'sd1, 32'sd1, 1'b1);
    send_beat(32'sd256, 0, 0, 1'b0);
    send_beat(32'sd65280, 32'sd2147483647, 32'sd2147483647, 1'b0);
    send_beat(32'sd100, 32'sd1, 0, 1'b0);
    send_random(230);

    load_settings(32'sd65536, 32'sd32768, 48'hFFFF_FFFF_FFFF, 48'd0, 32'sd33554432,
                  32'sd50331648, 1'b1);
    send_beat(32'sd98304, 32'sd65536, 0, 1'b1);
    send_random(230);

    send_idle = 53;
    recv_stall = 19;
    load_settings(-32'sh8000_0000, 32'sd2147483647, 48'd0, 48'hFFFF_FFFF_FFFF,
                  32'sd2147483647, -32'sh8000_0000, 1'b0);
    send_random(240);

    load_settings(32'sd2147483647, -32'sh8000_0000, 48'd1099511627776, 48'd1,
                  -32'sh8000_0000, 32'sd2147483647, 1'b1);
    send_random(240);

    send_idle = 0;
    recv_stall = 0;
    load_settings(32'($urandom), 32'sd1, 48'($urandom) << 16, 48'($urandom),
                  -32'sd100000000, -32'sd300000000, 1'b0);
    hold_req = 1'b1;
    send_random(240);

    load_settings(-32'sd65536, -32'sd20000, 48'd1099511627776, 48'd1099512,
                  32'($urandom_range(0, 32'h0800_0000)), -32'($urandom_range(0, 32'h1000_0000)),
                  1'b1);
    send_random(240);

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("smooth_switch_conductance_top: match");
    else
      $display("smooth_switch_conductance_top: mismatch");
    $finish;
  end
endmodule

FILE: smooth_switch_conductance_top.f
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_if.sv
hw/rtl/ssc_front.sv
hw/rtl/ssc_exp.sv
hw/rtl/ssc_mult.sv
hw/rtl/smooth_switch_conductance_top.sv
hw/rtl/ssc_checker.sv
test/smooth_switch_conductance_checker.sv
test/smooth_switch_conductance_top_test.sv
